// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/eds_pkg.sv
package eds_pkg;

  // Field widths fixed by the request and result formats.
  localparam int KIND_W    = 2;
  localparam int FLOOR_W   = 8;
  localparam int ELEV_ID_W = 3;
  localparam int PENALTY_W = 4;
  localparam int LOAD_W    = 8;

  localparam logic [PENALTY_W-1:0] PENALTY_RESET = 4'd2;
  localparam logic [LOAD_W-1:0]    LOAD_MAX      = 8'hFF;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    IN_FLOOR_REQ  = 2'd0,
    IN_POSITION   = 2'd1,
    IN_DISPATCH   = 2'd2,
    IN_COMPLETION = 2'd3
  } in_kind_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    RES_ASSIGNED    = 2'd0,
    RES_NO_ELEVATOR = 2'd1,
    RES_ARRIVAL     = 2'd2,
    RES_QUEUE_FULL  = 2'd3
  } res_kind_t;

  // Last assigned direction of an elevator.
  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_DOWN    = 2'd1,
    DIR_UP      = 2'd2
  } dir_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE     = 2'd0,
    BK_POP_WAIT = 2'd1,
    BK_SCAN     = 2'd2,
    BK_FINISH   = 2'd3
  } back_state_t;

  // Classified request as held in the command queue.
  typedef struct packed {
    in_kind_t               kind;
    logic [FLOOR_W-1:0]     floor;
    logic [FLOOR_W-1:0]     dest_floor;
    logic                   going_up;
    logic [ELEV_ID_W-1:0]   elevator_id;
    logic                   id_ok;
  } cmd_t;

  // Handshake between the command queue and the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } cmdq_status_t;

  // One result as held in the output register.
  typedef struct packed {
    res_kind_t              result_kind;
    logic [ELEV_ID_W-1:0]   elevator;
    logic [FLOOR_W-1:0]     floor;
    logic [FLOOR_W-1:0]     dest_floor;
    logic                   going_up;
  } result_t;

  localparam int CMDQ_DEPTH = 2;

endpackage

// File: src/eds_if.sv
// Request channel into the scheduler.
interface eds_in_if;
  import eds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [FLOOR_W-1:0]   floor;
  logic [FLOOR_W-1:0]   dest_floor;
  logic                 going_up;
  logic [ELEV_ID_W-1:0] elevator_id;

  modport source (output valid, kind, floor, dest_floor, going_up, elevator_id,
                  input ready);
  modport sink (input valid, kind, floor, dest_floor, going_up, elevator_id,
                output ready);
endinterface

// Result channel out of the scheduler.
interface eds_out_if;
  import eds_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    result_kind;
  logic [ELEV_ID_W-1:0] out_elevator;
  logic [FLOOR_W-1:0]   out_floor;
  logic [FLOOR_W-1:0]   out_dest_floor;
  logic                 out_going_up;

  modport source (output valid, result_kind, out_elevator, out_floor, out_dest_floor,
                  out_going_up, input ready);
  modport sink (input valid, result_kind, out_elevator, out_floor, out_dest_floor,
                out_going_up, output ready);
endinterface

// File: src/eds_front.sv
module eds_front #(
  parameter int NUM_ELEVATORS = 8,
  parameter int FLOOR_BITS    = 8
) (
  eds_in_if.sink         in_ch,
  input  logic           cmdq_full,
  output logic           cmd_push,
  output eds_pkg::cmd_t  cmd_data
);
  import eds_pkg::*;

  // Floors are kept to FLOOR_BITS, never wider than the port.
  localparam int FW = (FLOOR_BITS < FLOOR_W) ? FLOOR_BITS : FLOOR_W;
  localparam logic [FLOOR_W-1:0] FLOOR_MASK = FLOOR_W'((32'd1 << FW) - 32'd1);

  // A request is taken whenever the command queue has room.
  assign in_ch.ready = !cmdq_full;
  assign cmd_push    = in_ch.valid && !cmdq_full;

  // Decode the kind, mask the floors and check the elevator id once here.
  always_comb begin
    cmd_data.kind        = in_kind_t'(in_ch.kind);
    cmd_data.floor       = in_ch.floor & FLOOR_MASK;
    cmd_data.dest_floor  = in_ch.dest_floor & FLOOR_MASK;
    cmd_data.going_up    = in_ch.going_up;
    cmd_data.elevator_id = in_ch.elevator_id;
    cmd_data.id_ok       = (int'(in_ch.elevator_id) < NUM_ELEVATORS);
  end

endmodule

// File: src/eds_cmd_queue.sv
module eds_cmd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  eds_pkg::cmd_t        push_data,
  input  logic                 pop,
  output eds_pkg::cmd_t        head_data,
  output eds_pkg::cmdq_status_t status
);
  import eds_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          slot_r [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(CMDQ_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_data    = slot_r[rd_ptr_r];

  // Pointer and fill count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue slots carry payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/eds_req_fifo.sv
module eds_req_fifo #(
  parameter int DEPTH = 16,
  parameter int FW    = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [FW-1:0]   wr_floor,
  input  logic [FW-1:0]   wr_dest,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output logic [2*FW-1:0] rd_data_r
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_S = (AW + 1)'(DEPTH);

  logic [2*FW-1:0] mem [DEPTH];
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW:0]     tail_sum;
  logic [AW:0]     head_inc;
  logic [AW-1:0]   tail;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Tail is head plus count, wrapped by one compare and subtract.
  assign tail_sum = (AW + 1)'(head_r) + (AW + 1)'(count_r);
  assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign head_inc = (AW + 1)'(head_r) + 1'b1;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (do_pop) begin
      head_nxt  = (head_inc == DEPTH_S) ? '0 : AW'(head_inc);
      count_nxt = count_r - 1'b1;
    end else if (do_push) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry store with a registered read port for the head entry.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= {wr_floor, wr_dest};
    end
    if (do_pop) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

// File: src/eds_back.sv
module eds_back #(
  parameter int NUM_ELEVATORS = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int FLOOR_BITS    = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  eds_pkg::cmd_t                     cmd_data,
  input  eds_pkg::cmdq_status_t             cmdq_status,
  output logic                              cmd_pop,
  input  logic [eds_pkg::PENALTY_W-1:0]     penalty,
  eds_out_if.source                         out_ch
);
  import eds_pkg::*;

  localparam int FW = (FLOOR_BITS < FLOOR_W) ? FLOOR_BITS : FLOOR_W;
  localparam int EW = (NUM_ELEVATORS > 1) ? $clog2(NUM_ELEVATORS) : 1;
  localparam int DW = ((FW > PENALTY_W) ? FW : PENALTY_W) + 1;
  localparam logic [EW-1:0] LAST_ELEV = EW'(NUM_ELEVATORS - 1);

  // Elevator table: floors are payload, the rest resets.
  logic [FW-1:0]     elev_floor_r [NUM_ELEVATORS];
  logic              known_r      [NUM_ELEVATORS];
  dir_t              dir_r        [NUM_ELEVATORS];
  logic [LOAD_W-1:0] load_r       [NUM_ELEVATORS];

  back_state_t       state_r, state_nxt;
  logic [EW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              req_up_r, req_up_nxt;
  logic              found_r, found_nxt;
  logic [EW-1:0]     best_r, best_nxt;
  logic [LOAD_W-1:0] best_load_r, best_load_nxt;
  logic [DW-1:0]     best_dist_r, best_dist_nxt;
  logic              res_valid_r, res_valid_nxt;
  result_t           res_r, res_nxt;

  // Table write controls.
  logic              pos_we;
  logic              load_we;
  logic [EW-1:0]     load_waddr;
  logic [LOAD_W-1:0] load_wdata;
  logic              dir_we;
  dir_t              dir_wdata;

  // Request FIFO controls.
  logic              up_push, dn_push, up_pop, dn_pop;
  logic              up_full, dn_full, up_empty, dn_empty;
  logic [2*FW-1:0]   up_rd, dn_rd;

  // Single table read port, shared by the scan and by completions.
  logic [EW-1:0]     id_idx;
  logic [EW-1:0]     rd_addr;
  logic [FW-1:0]     rd_floor;
  logic              rd_known;
  dir_t              rd_dir;
  logic [LOAD_W-1:0] rd_load;

  // Request being dispatched and its distance to the scanned elevator.
  logic [2*FW-1:0]   req_entry;
  logic [FW-1:0]     req_floor;
  logic [FW-1:0]     req_dest;
  dir_t              req_dir;
  logic [FW-1:0]     abs_diff;
  logic [DW-1:0]     cand_dist;
  logic              out_free;

  assign id_idx   = EW'(cmd_data.elevator_id);
  assign rd_addr  = (state_r == BK_SCAN) ? scan_idx_r : id_idx;
  assign rd_floor = elev_floor_r[rd_addr];
  assign rd_known = known_r[rd_addr];
  assign rd_dir   = dir_r[rd_addr];
  assign rd_load  = load_r[rd_addr];

  assign req_entry = req_up_r ? up_rd : dn_rd;
  assign req_floor = req_entry[2*FW-1:FW];
  assign req_dest  = req_entry[FW-1:0];
  assign req_dir   = req_up_r ? DIR_UP : DIR_DOWN;
  assign abs_diff  = (rd_floor >= req_floor) ? rd_floor - req_floor : req_floor - rd_floor;
  assign cand_dist = DW'(abs_diff) +
                     (((rd_dir != DIR_UNKNOWN) && (rd_dir != req_dir)) ? DW'(penalty) : '0);

  assign out_free = !res_valid_r || out_ch.ready;

  eds_req_fifo #(.DEPTH(QUEUE_DEPTH), .FW(FW)) u_up_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (up_push),
    .wr_floor (cmd_data.floor[FW-1:0]),
    .wr_dest  (cmd_data.dest_floor[FW-1:0]),
    .pop      (up_pop),
    .full     (up_full),
    .empty    (up_empty),
    .rd_data_r(up_rd)
  );

  eds_req_fifo #(.DEPTH(QUEUE_DEPTH), .FW(FW)) u_dn_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (dn_push),
    .wr_floor (cmd_data.floor[FW-1:0]),
    .wr_dest  (cmd_data.dest_floor[FW-1:0]),
    .pop      (dn_pop),
    .full     (dn_full),
    .empty    (dn_empty),
    .rd_data_r(dn_rd)
  );

  // Sequencer: one command at a time, one elevator per cycle in the scan.
  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    req_up_nxt    = req_up_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_load_nxt = best_load_r;
    best_dist_nxt = best_dist_r;
    res_valid_nxt = res_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    cmd_pop       = 1'b0;
    pos_we        = 1'b0;
    load_we       = 1'b0;
    load_waddr    = id_idx;
    load_wdata    = rd_load;
    dir_we        = 1'b0;
    dir_wdata     = req_dir;
    up_push       = 1'b0;
    dn_push       = 1'b0;
    up_pop        = 1'b0;
    dn_pop        = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!cmdq_status.empty && out_free) begin
          cmd_pop = 1'b1;
          case (cmd_data.kind)
            IN_FLOOR_REQ: begin
              if (cmd_data.going_up ? up_full : dn_full) begin
                res_valid_nxt       = 1'b1;
                res_nxt.result_kind = RES_QUEUE_FULL;
                res_nxt.elevator    = '0;
                res_nxt.floor       = cmd_data.floor;
                res_nxt.dest_floor  = cmd_data.dest_floor;
                res_nxt.going_up    = cmd_data.going_up;
              end else begin
                up_push = cmd_data.going_up;
                dn_push = !cmd_data.going_up;
              end
            end
            IN_POSITION: begin
              pos_we = cmd_data.id_ok;
            end
            IN_DISPATCH: begin
              if (!up_empty) begin
                up_pop     = 1'b1;
                req_up_nxt = 1'b1;
                state_nxt  = BK_POP_WAIT;
              end else if (!dn_empty) begin
                dn_pop     = 1'b1;
                req_up_nxt = 1'b0;
                state_nxt  = BK_POP_WAIT;
              end
            end
            IN_COMPLETION: begin
              // Load is lowered only for a real elevator that has work.
              if (cmd_data.id_ok && (rd_load != '0)) begin
                load_we    = 1'b1;
                load_wdata = rd_load - 1'b1;
              end
              res_valid_nxt       = 1'b1;
              res_nxt.result_kind = RES_ARRIVAL;
              res_nxt.elevator    = cmd_data.elevator_id;
              res_nxt.floor       = cmd_data.floor;
              res_nxt.dest_floor  = cmd_data.dest_floor;
              res_nxt.going_up    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_POP_WAIT: begin
        scan_idx_nxt = '0;
        found_nxt    = 1'b0;
        state_nxt    = BK_SCAN;
      end
      BK_SCAN: begin
        // Least load wins; equal load goes to the shorter distance, a full tie to the lower index.
        if (rd_known && (!found_r || (rd_load < best_load_r) ||
                         ((rd_load == best_load_r) && (cand_dist < best_dist_r)))) begin
          found_nxt     = 1'b1;
          best_nxt      = scan_idx_r;
          best_load_nxt = rd_load;
          best_dist_nxt = cand_dist;
        end
        if (scan_idx_r == LAST_ELEV) begin
          state_nxt = BK_FINISH;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      BK_FINISH: begin
        res_valid_nxt      = 1'b1;
        res_nxt.floor      = FLOOR_W'(req_floor);
        res_nxt.dest_floor = FLOOR_W'(req_dest);
        res_nxt.going_up   = req_up_r;
        if (found_r) begin
          load_we             = 1'b1;
          load_waddr          = best_r;
          load_wdata          = (best_load_r == LOAD_MAX) ? best_load_r : best_load_r + 1'b1;
          dir_we              = 1'b1;
          res_nxt.result_kind = RES_ASSIGNED;
          res_nxt.elevator    = ELEV_ID_W'(best_r);
        end else begin
          res_nxt.result_kind = RES_NO_ELEVATOR;
          res_nxt.elevator    = '0;
        end
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Working registers of the scan and the output payload.
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    req_up_r    <= req_up_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    best_load_r <= best_load_nxt;
    best_dist_r <= best_dist_nxt;
    res_r       <= res_nxt;
  end

  // Known flags, directions and loads are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ELEVATORS; i++) begin
        known_r[i] <= 1'b0;
        dir_r[i]   <= DIR_UNKNOWN;
        load_r[i]  <= '0;
      end
    end else begin
      if (pos_we) begin
        known_r[id_idx] <= 1'b1;
      end
      if (load_we) begin
        load_r[load_waddr] <= load_wdata;
      end
      if (dir_we) begin
        dir_r[best_r] <= dir_wdata;
      end
    end
  end

  // Elevator floors carry no reset; the scan only uses the floor of a known elevator.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      elev_floor_r[id_idx] <= cmd_data.floor[FW-1:0];
    end
  end

  assign out_ch.valid          = res_valid_r;
  assign out_ch.result_kind    = res_r.result_kind;
  assign out_ch.out_elevator   = res_r.elevator;
  assign out_ch.out_floor      = res_r.floor;
  assign out_ch.out_dest_floor = res_r.dest_floor;
  assign out_ch.out_going_up   = res_r.going_up;

endmodule

// File: src/elevator_dispatch_scheduler_core.sv
// Elevator dispatch scheduler. Requests are taken into a two-entry command
// queue whenever it has room, so the request side keeps moving while a result
// waits in the output register. The back end carries out one request at a
// time. A dispatch passes through the registered read of the request FIFO,
// then a scan that visits one elevator table entry per cycle through a
// single read port. Floor requests that find their FIFO full, dispatches
// that find a waiting floor request, and completions each return one
// result; the others return none. The penalty register may only be written
// while no request is in progress.
module elevator_dispatch_scheduler_core #(
  parameter int NUM_ELEVATORS = 8,
  parameter int QUEUE_DEPTH   = 16,
  parameter int FLOOR_BITS    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  eds_in_if.sink                        in_ch,
  eds_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [eds_pkg::PENALTY_W-1:0] cfg_wdata
);
  import eds_pkg::*;

  logic [PENALTY_W-1:0] penalty_r, penalty_nxt;
  logic                 cmd_push;
  cmd_t                 cmd_in;
  cmd_t                 cmd_head;
  logic                 cmd_pop;
  cmdq_status_t         cmdq_status;

  // Direction penalty register.
  assign penalty_nxt = cfg_we ? cfg_wdata : penalty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_r <= PENALTY_RESET;
    end else begin
      penalty_r <= penalty_nxt;
    end
  end

  eds_front #(
    .NUM_ELEVATORS(NUM_ELEVATORS),
    .FLOOR_BITS   (FLOOR_BITS)
  ) u_front (
    .in_ch    (in_ch),
    .cmdq_full(cmdq_status.full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  eds_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .pop      (cmd_pop),
    .head_data(cmd_head),
    .status   (cmdq_status)
  );

  eds_back #(
    .NUM_ELEVATORS(NUM_ELEVATORS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .FLOOR_BITS   (FLOOR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_data   (cmd_head),
    .cmdq_status(cmdq_status),
    .cmd_pop    (cmd_pop),
    .penalty    (penalty_r),
    .out_ch     (out_ch)
  );

endmodule

// File: src/eds_checker.sv
`include "assert_macros.svh"

module eds_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] result_kind,
  input logic [2:0] out_elevator,
  input logic [7:0] out_floor,
  input logic [7:0] out_dest_floor,
  input logic       out_going_up
);
  import eds_pkg::*;

  // A result that is not taken stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_stable, clk, rst_n, (out_valid && !out_ready) |=> ($stable(result_kind) && $stable(out_elevator) && $stable(out_floor) && $stable(out_dest_floor) && $stable(out_going_up)), "result changed while stalled")

  // Arrival notices carry no direction.
  `ASSERT_CLK(a_arrival_dir, clk, rst_n, (out_valid && (result_kind == RES_ARRIVAL)) |-> !out_going_up, "arrival notice with direction set")

  // Drops and unserved dispatches name no elevator.
  `ASSERT_CLK(a_no_elev_id, clk, rst_n, (out_valid && ((result_kind == RES_NO_ELEVATOR) || (result_kind == RES_QUEUE_FULL))) |-> (out_elevator == 3'd0), "unexpected elevator id")

  // Reset leaves no result on offer.
  `ASSERT_CLK_NR(a_reset_idle, clk, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind elevator_dispatch_scheduler_core eds_checker u_eds_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_kind   (out_ch.result_kind),
  .out_elevator  (out_ch.out_elevator),
  .out_floor     (out_ch.out_floor),
  .out_dest_floor(out_ch.out_dest_floor),
  .out_going_up  (out_ch.out_going_up)
);
